@@ rtl/pbfd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the run-length frame decoder: widths, codes, decode modes
// and the result word that travels from the front end to the output stage.
// No dependencies.
package pbfd_pkg;

    localparam int POSITION_BITS = 24;
    localparam int PIXEL_COUNT_W = 23;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 8;

    // Frame size: three values per pixel, saturated to the position range
    localparam int VALUES_PER_PIXEL = 3;
    localparam int TOTAL_W = (PIXEL_COUNT_W + 2 > POSITION_BITS + 1) ?
                             PIXEL_COUNT_W + 2 : POSITION_BITS + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    localparam logic [BYTE_W-1:0] IDLE_SKIP_BYTE = 8'h45;
    localparam logic [BYTE_W-1:0] RUN_BIAS       = 8'd2;  // copies = 2 - c

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_PIXEL_COUNT = 3'h0;
    localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET = 23'd307200;

    // Result queue between front end and output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_LIT   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0]        byte_value;
        logic [COUNT_W-1:0]       repeat_count;
        logic [POSITION_BITS-1:0] start_position;
        logic                     frame_done;
        logic                     run_clipped;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t item;
    } push_t;

endpackage

@@ rtl/pbfd_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts stream bytes, tracks the frame/block mode and the
// frame position, and builds result words. Depends on pbfd_pkg.
module pbfd_front
    import pbfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [BYTE_W-1:0]        data_byte,
    input  logic [PIXEL_COUNT_W-1:0] pixel_count,
    input  logic                     queue_full,
    output push_t                    push_out
);

    mode_t                    mode_reg, mode_next;
    logic [COUNT_W-1:0]       run_length_reg, run_length_next;
    logic [COUNT_W-1:0]       literals_left_reg, literals_left_next;
    logic [POSITION_BITS-1:0] values_done_reg, values_done_next;
    logic [POSITION_BITS-1:0] frame_total_reg, frame_total_next;

    logic                     accept;
    logic [TOTAL_W-1:0]       pc_ext;
    logic [TOTAL_W-1:0]       triple;
    logic [POSITION_BITS-1:0] total_sat;
    logic [POSITION_BITS-1:0] left;
    logic [POSITION_BITS-1:0] run_ext;
    logic                     clip;
    logic [POSITION_BITS-1:0] run_n;
    logic [POSITION_BITS-1:0] done_after_run;
    logic [POSITION_BITS-1:0] done_after_lit;
    logic [COUNT_W-1:0]       lit_dec;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign pc_ext    = TOTAL_W'(pixel_count);
    assign triple    = (pc_ext << 1) + pc_ext;
    assign total_sat = (triple > TOTAL_W'(POS_MAX)) ? POS_MAX : triple[POSITION_BITS-1:0];

    assign left    = (frame_total_reg > values_done_reg) ?
                     (frame_total_reg - values_done_reg) : '0;
    assign run_ext = POSITION_BITS'(run_length_reg);
    assign clip    = run_ext > left;
    assign run_n   = clip ? left : run_ext;
    assign done_after_run = values_done_reg + run_n;
    assign done_after_lit = values_done_reg + POSITION_BITS'(1);
    assign lit_dec = (literals_left_reg != '0) ? literals_left_reg - COUNT_W'(1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            run_length_reg    <= '0;
            literals_left_reg <= '0;
            values_done_reg   <= '0;
            frame_total_reg   <= '0;
        end
        else
        begin
            mode_reg          <= mode_next;
            run_length_reg    <= run_length_next;
            literals_left_reg <= literals_left_next;
            values_done_reg   <= values_done_next;
            frame_total_reg   <= frame_total_next;
        end
    end

    always_comb
    begin
        mode_next          = mode_reg;
        run_length_next    = run_length_reg;
        literals_left_next = literals_left_reg;
        values_done_next   = values_done_reg;
        frame_total_next   = frame_total_reg;
        push_out           = '0;
        push_out.item.byte_value = data_byte;

        if (accept)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    // open a frame on any marker byte, unless the frame is empty
                    if (data_byte != IDLE_SKIP_BYTE && total_sat != '0)
                    begin
                        frame_total_next = total_sat;
                        values_done_next = '0;
                        mode_next        = MODE_COUNT;
                    end
                end
                MODE_COUNT:
                begin
                    if (data_byte[BYTE_W-1])
                    begin
                        run_length_next = RUN_BIAS - data_byte;
                        mode_next       = MODE_RUN;
                    end
                    else
                    begin
                        literals_left_next = data_byte + COUNT_W'(1);
                        mode_next          = MODE_LIT;
                    end
                end
                MODE_RUN:
                begin
                    push_out.push                = 1'b1;
                    push_out.item.repeat_count   = run_n[COUNT_W-1:0];
                    push_out.item.start_position = values_done_reg;
                    push_out.item.frame_done     = done_after_run >= frame_total_reg;
                    push_out.item.run_clipped    = clip;
                    run_length_next  = '0;
                    values_done_next = done_after_run;
                    mode_next = (done_after_run >= frame_total_reg) ? MODE_IDLE : MODE_COUNT;
                end
                MODE_LIT:
                begin
                    // past the frame end, drop the rest of the literal block
                    if (values_done_reg < frame_total_reg)
                    begin
                        push_out.push                = 1'b1;
                        push_out.item.repeat_count   = COUNT_W'(1);
                        push_out.item.start_position = values_done_reg;
                        push_out.item.frame_done     = done_after_lit >= frame_total_reg;
                        values_done_next             = done_after_lit;
                    end
                    literals_left_next = lit_dec;
                    if (lit_dec == '0)
                    begin
                        mode_next = (values_done_next >= frame_total_reg) ?
                                    MODE_IDLE : MODE_COUNT;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push_out.push |-> accept)
        else $error("result pushed without an accepted byte");

    a_run_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_RUN |-> (run_length_reg >= COUNT_W'(3)))
        else $error("pending run shorter than three copies");

    a_position_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_IDLE |-> (values_done_reg <= frame_total_reg))
        else $error("frame position beyond frame size");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push_out.push)
        else $error("push into a full queue");

endmodule

@@ rtl/pbfd_queue.sv @@
`timescale 1ns / 1ps
// Short result queue between the front end and the output stage.
// Depends on pbfd_pkg.
module pbfd_queue
    import pbfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push_in,
    input  logic    pop,
    output logic    full,
    output logic    empty,
    output result_t head
);

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_in.item;
        end
    end

endmodule

@@ rtl/pbfd_back.sv @@
`timescale 1ns / 1ps
// Output stage: pulls result words from the queue into the output
// register and holds them until taken. Depends on pbfd_pkg.
module pbfd_back
    import pbfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    queue_empty,
    input  result_t queue_head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    logic    valid_reg, valid_next;
    result_t item_reg;

    // advance when the register is free or its word leaves this cycle
    assign pop       = !queue_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= queue_head;
        end
    end

endmodule

@@ rtl/packbits_frame_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the run-length frame decoder: configuration register,
// front end, result queue and output stage. Depends on pbfd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte) takes one compressed stream
//   byte per word. Output channel (out_valid/out_ready) delivers decoded
//   words: byte_value, repeat_count, start_position, frame_done, run_clipped.
//   In idle, 0x45 bytes are skipped; any other byte opens a frame of
//   3 * pixel_count values (saturated to the position range). Count bytes
//   select a run (one word with 3..130 copies) or a literal block (one word
//   per byte). A run reaching past the frame end is cut and flagged; literal
//   bytes past the frame end are consumed and dropped.
//   Throughput: one byte per clock while the queue has room, set by the
//   single-step front end update. A result word is written to the queue
//   at the edge that accepts its byte, then loaded into the output register
//   once that register is free or its word is taken.
//   When the receiver stalls, the output register holds its word, the
//   two-entry queue absorbs results, and in_ready drops once it is full.
//   Reset clears the mode, counters, queue and output valid; pixel_count
//   returns to 307200. Write pixel_count (address 0) only while idle.
module packbits_frame_decoder_top
    import pbfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [BYTE_W-1:0]        data_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [BYTE_W-1:0]        byte_value,
    output logic [COUNT_W-1:0]       repeat_count,
    output logic [POSITION_BITS-1:0] start_position,
    output logic                     frame_done,
    output logic                     run_clipped
);

    logic [PIXEL_COUNT_W-1:0] pixel_count_reg, pixel_count_next;
    logic                     cfg_write;
    push_t                    push;
    logic                     queue_full;
    logic                     queue_empty;
    logic                     pop;
    result_t                  queue_head;
    result_t                  out_item;

    // Configuration: zero-wait APB, single register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_PIXEL_COUNT);
    assign pixel_count_next = cfg_write ? pwdata[PIXEL_COUNT_W-1:0] : pixel_count_reg;
    assign prdata = (paddr == ADDR_PIXEL_COUNT) ? PDATA_W'(pixel_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= PIXEL_COUNT_RESET;
        end
        else
        begin
            pixel_count_reg <= pixel_count_next;
        end
    end

    // Classify bytes and build result words
    pbfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .pixel_count (pixel_count_reg),
        .queue_full  (queue_full),
        .push_out    (push)
    );

    // Decouple front end from output stalls
    pbfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .full    (queue_full),
        .empty   (queue_empty),
        .head    (queue_head)
    );

    // Hold the current word until the receiver takes it
    pbfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_head  (queue_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    assign byte_value     = out_item.byte_value;
    assign repeat_count   = out_item.repeat_count;
    assign start_position = out_item.start_position;
    assign frame_done     = out_item.frame_done;
    assign run_clipped    = out_item.run_clipped;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for packbits_frame_decoder_top: streams compressed bytes,
// predicts every decoded word and checks each one as it leaves the block.
// Depends on pbfd_pkg and the decoder RTL.
module tb_top;

    import pbfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 32;
    localparam int STALL_CYCLES = 300;

    // ------------------------------------------------------------------
    // Block inputs start at known values
    // ------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [BYTE_W-1:0]        data_byte = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [BYTE_W-1:0]        byte_value;
    logic [COUNT_W-1:0]       repeat_count;
    logic [POSITION_BITS-1:0] start_position;
    logic                     frame_done;
    logic                     run_clipped;

    // ------------------------------------------------------------------
    // Decoder state as the bench sees it, plus the words it still owes
    // ------------------------------------------------------------------
    mode_t                    dec_mode = MODE_IDLE;
    logic [COUNT_W-1:0]       pend_copies = '0;
    logic [COUNT_W-1:0]       lits_to_go = '0;
    logic [POSITION_BITS-1:0] placed = '0;
    logic [POSITION_BITS-1:0] frame_size = '0;
    logic [PIXEL_COUNT_W-1:0] cfg_pixels = PIXEL_COUNT_RESET;
    result_t                  expected_words[$];
    result_t                  head_word;

    int idle_pct = IDLE_PCT;
    int stall_cmd = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int words_checked = 0;
    int frames_opened = 0;
    int clipped_seen = 0;

    packbits_frame_decoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_value     (byte_value),
        .repeat_count   (repeat_count),
        .start_position (start_position),
        .frame_done     (frame_done),
        .run_clipped    (run_clipped)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake ends the run here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Mismatch bookkeeping: show the first ten, count the rest
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Prediction. Queue one decoded word and advance the frame position.
    // ------------------------------------------------------------------
    task automatic post_word(input logic [BYTE_W-1:0] v, input logic [COUNT_W-1:0] n,
                             input logic clipped);
        result_t w;
        w.byte_value     = v;
        w.repeat_count   = n;
        w.start_position = placed;
        placed           = placed + n;
        w.frame_done     = (placed >= frame_size);
        w.run_clipped    = clipped;
        expected_words.push_back(w);
    endtask

    // Advance the decoder state by one accepted stream byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [25:0]              want;
        logic [POSITION_BITS:0]   room;
        logic [COUNT_W-1:0]       n;
        logic                     clipped;
        case (dec_mode)
            MODE_IDLE:
            begin
                // Skip 'E'; anything else opens a frame unless the size is zero
                if (b != IDLE_SKIP_BYTE)
                begin
                    want = 26'(cfg_pixels) * 26'(VALUES_PER_PIXEL);
                    if (want > 26'(POS_MAX))
                        want = 26'(POS_MAX);
                    if (want != '0)
                    begin
                        frame_size = want[POSITION_BITS-1:0];
                        placed     = '0;
                        dec_mode   = MODE_COUNT;
                        frames_opened++;
                    end
                end
            end
            MODE_COUNT:
            begin
                if (b[7])
                begin
                    pend_copies = RUN_BIAS - b;  // 2 - c, 3..130
                    dec_mode    = MODE_RUN;
                end
                else
                begin
                    lits_to_go = b + 8'd1;
                    dec_mode   = MODE_LIT;
                end
            end
            MODE_RUN:
            begin
                if (frame_size > placed)
                    room = {1'b0, frame_size} - {1'b0, placed};
                else
                    room = '0;
                n       = pend_copies;
                clipped = 1'b0;
                // Cut a run that reaches past the frame end
                if ((POSITION_BITS + 1)'(n) > room)
                begin
                    n       = room[COUNT_W-1:0];
                    clipped = 1'b1;
                end
                pend_copies = '0;
                post_word(b, n, clipped);
                if (placed >= frame_size)
                    dec_mode = MODE_IDLE;
                else
                    dec_mode = MODE_COUNT;
            end
            default:
            begin
                // Literals past the frame end are eaten silently
                if (placed < frame_size)
                    post_word(b, 8'd1, 1'b0);
                if (lits_to_go != '0)
                    lits_to_go--;
                if (lits_to_go == '0)
                begin
                    if (placed >= frame_size)
                        dec_mode = MODE_IDLE;
                    else
                        dec_mode = MODE_COUNT;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side: offer one byte, hold it until accepted
    // ------------------------------------------------------------------
    task automatic push_stream_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        decode_byte(b);
    endtask

    // Pick the next byte from the current decode mode: mostly well-formed
    // frames with random content, with some raw noise mixed in
    function automatic logic [BYTE_W-1:0] pick_stream_byte();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return BYTE_W'($urandom);
        case (dec_mode)
            MODE_IDLE:
                if (r < 20)
                    return IDLE_SKIP_BYTE;
                else
                    return BYTE_W'($urandom);
            MODE_COUNT:
                if (r < 55)
                    return BYTE_W'($urandom_range(255, 128));
                else if (r < 90)
                    return BYTE_W'($urandom_range(15, 0));
                else
                    return BYTE_W'($urandom_range(127, 0));
            default:
                return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic stream_random(input int n);
        repeat (n)
            push_stream_byte(pick_stream_byte());
    endtask

    // Drop valid and wait out every owed word plus the pipeline depth,
    // so a register write lands on a quiet block
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Close any open frame quickly with long runs, then drain
    task automatic finish_phase();
        while (dec_mode != MODE_IDLE)
        begin
            if (dec_mode == MODE_COUNT)
                push_stream_byte(8'h80);
            else
                push_stream_byte(BYTE_W'($urandom));
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup then access, pready honored
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_PIXEL_COUNT;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_pixel_readback();
        logic [PDATA_W-1:0] got;
        apb_access(1'b0, '0, got);
        if (got !== PDATA_W'(cfg_pixels))
            note_mismatch($sformatf("pixel_count read %0d, expected %0d", got, cfg_pixels));
    endtask

    task automatic set_pixel_count(input logic [PDATA_W-1:0] v);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, v, unused);
        cfg_pixels = v[PIXEL_COUNT_W-1:0];
        check_pixel_readback();
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready, or a counted hold-off when asked
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_cmd != 0)
        begin
            hold_left = stall_cmd;
            stall_cmd = 0;
        end
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Compare each delivered word against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                note_mismatch($sformatf("unexpected word value %02h count %0d pos %0d",
                                        byte_value, repeat_count, start_position));
            else
            begin
                head_word = expected_words.pop_front();
                if (byte_value !== head_word.byte_value ||
                    repeat_count !== head_word.repeat_count ||
                    start_position !== head_word.start_position ||
                    frame_done !== head_word.frame_done ||
                    run_clipped !== head_word.run_clipped)
                    note_mismatch($sformatf(
                        "exp val %02h cnt %0d pos %0d done %b clip %b / got %02h %0d %0d %b %b",
                        head_word.byte_value, head_word.repeat_count,
                        head_word.start_position, head_word.frame_done,
                        head_word.run_clipped, byte_value, repeat_count,
                        start_position, frame_done, run_clipped));
                words_checked++;
                if (head_word.run_clipped)
                    clipped_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_reset();
        check_pixel_readback();
    endtask

    // Six-value frames: skipped 'E', a clipped 130-copy run, two runs that end
    // the frame exactly, extreme values, and a literal block that overruns
    // the frame end so its tail bytes are dropped
    task automatic test_directed_frames();
        logic [BYTE_W-1:0] seq[$];
        seq = '{8'h45, 8'hFF, 8'h80, 8'h3C,
                8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA,
                8'h46, 8'h02, 8'hFF, 8'h01, 8'h80, 8'h05,
                8'h7F, 8'h55, 8'hFE, 8'h11, 8'h22, 8'h33,
                8'h45};
        set_pixel_count(2);
        foreach (seq[i])
            push_stream_byte(seq[i]);
        drain_results();
    endtask

    // A zero frame size: markers open nothing and no word comes out
    task automatic test_zero_pixel_count();
        set_pixel_count(0);
        push_stream_byte(8'h10);
        push_stream_byte(8'h80);
        drain_results();
        if (dec_mode != MODE_IDLE)
            note_mismatch("zero pixel count opened a frame");
    endtask

    task automatic test_tiny_frames();
        set_pixel_count(1);
        stream_random(150);
        finish_phase();
        set_pixel_count(3);
        stream_random(150);
        finish_phase();
    endtask

    // Hold the output off while the sender keeps offering: the queue fills
    // and in_ready must drop without losing a word
    task automatic test_output_backpressure();
        set_pixel_count(50);
        @(posedge clk);
        stall_cmd = STALL_CYCLES;
        stream_random(250);
        finish_phase();
    endtask

    // A long stretch at full rate on both sides
    task automatic test_full_rate();
        idle_pct = 0;
        set_pixel_count($urandom_range(100, 1));
        stream_random(250);
        finish_phase();
        idle_pct = IDLE_PCT;
    endtask

    // Let the sender pause mid-frame until every word has come back
    task automatic test_sender_pause();
        set_pixel_count(7);
        stream_random(75);
        drain_results();
        stream_random(75);
        finish_phase();
    endtask

    // Largest legal size, then all ones (saturates the frame size); the last
    // frame is far too big to close, so leave it open at the end of the run
    task automatic test_largest_frames();
        set_pixel_count(5592405);
        set_pixel_count(32'hFFFF_FFFF);
        push_stream_byte(8'h00);
        stream_random(60);
        drain_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset();
        test_directed_frames();
        test_zero_pixel_count();
        test_tiny_frames();
        test_output_backpressure();
        test_full_rate();
        test_sender_pause();
        test_largest_frames();

        repeat (10) @(posedge clk);
        if (mismatches > 10)
            $display("%0d further mismatches not shown", mismatches - 10);
        $display("Run covered %0d stream bytes, %0d decoded words, %0d frames, %0d clipped runs",
                 bytes_sent, words_checked, frames_opened, clipped_seen);
        $display("Frame sizes from zero to saturated, one %0d-cycle output stall",
                 STALL_CYCLES);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
